>>> sv/twis_pkg.sv
// ----------------------------------------------------------------------------
// twis_pkg: shared types and constants for the trie word insert/search block
// Item and result payloads, command codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package twis_pkg;

    localparam int LETTER_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;    // clearing pass: zero one link entry per cycle, and one mark while marks remain
        logic capture;  // take the item and start the child link read
        logic step;     // follow, allocate or flag using the link read data
        logic finish;   // read and possibly set the word end mark
        logic emit;     // load the result register and return to the root
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic last;
        logic out_free;
    } ctrl_stat_t;

endpackage

>>> sv/twis_ctrl.sv
// ----------------------------------------------------------------------------
// twis_ctrl: sequencing state machine
// Runs the clearing pass after reset, then takes one letter at a time
// through capture, walk, and for the final letter, mark and result.
// ----------------------------------------------------------------------------
module twis_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  twis_pkg::ctrl_stat_t  stat,
    output twis_pkg::ctrl_cmd_t   cmd
);
    import twis_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.step   = 1'b1;
                state_next = stat.last ? S_MARK : S_IDLE;
            end
            S_MARK:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register can take the transfer
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

>>> sv/twis_dp.sv
// ----------------------------------------------------------------------------
// twis_dp: trie datapath
// Child link and word end memories, cursor, node allocation counter,
// word flags, clearing counter and the result register.
// ----------------------------------------------------------------------------
module twis_dp #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  twis_pkg::in_item_t    item,
    input  twis_pkg::ctrl_cmd_t   cmd,
    output twis_pkg::ctrl_stat_t  stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output twis_pkg::out_item_t   result
);
    import twis_pkg::*;

    localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int NW = $clog2(NODE_COUNT);
    localparam int UW = $clog2(NODE_COUNT + 1);
    localparam int AW = $clog2(LINK_DEPTH);
    localparam int CW = $clog2(LINK_DEPTH + 1);

    logic [NW-1:0] link_mem [LINK_DEPTH];
    logic          mark_mem [NODE_COUNT];

    in_item_t      item_reg;
    logic [AW-1:0] slot_reg;
    logic [NW-1:0] link_rd_reg;
    logic          mark_rd_reg;
    out_item_t     result_reg;
    out_item_t     result_next;

    logic [NW-1:0] cursor_reg;
    logic [NW-1:0] cursor_next;
    logic [UW-1:0] nodes_used_reg;
    logic [UW-1:0] nodes_used_next;
    logic          path_missing_reg;
    logic          path_missing_next;
    logic          pool_overflow_reg;
    logic          pool_overflow_next;
    logic [CW-1:0] clr_cnt_reg;
    logic [CW-1:0] clr_cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic          broken;
    logic          bad_letter;
    logic          in_letter_ok;
    logic          pool_full;
    logic          alloc;
    logic          word_ok;
    logic [AW-1:0] rd_addr;
    logic          link_clr;
    logic          mark_clr;
    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [NW-1:0] link_wdata;
    logic          mark_we;
    logic [NW-1:0] mark_addr;

    assign broken       = path_missing_reg | pool_overflow_reg;
    assign bad_letter   = 32'(item_reg.letter) >= ALPHABET_SIZE;
    assign in_letter_ok = 32'(item.letter) < ALPHABET_SIZE;
    assign pool_full    = nodes_used_reg >= UW'(NODE_COUNT);
    assign word_ok      = !broken;
    assign rd_addr      = AW'(cursor_reg) * AW'(ALPHABET_SIZE) + AW'(item.letter);

    assign alloc = cmd.step && !broken && !bad_letter && (link_rd_reg == '0)
                   && (item_reg.cmd == CMD_INSERT) && !pool_full;

    assign link_clr   = cmd.clear && (clr_cnt_reg < CW'(LINK_DEPTH));
    assign mark_clr   = cmd.clear && (clr_cnt_reg < CW'(NODE_COUNT));
    assign link_we    = link_clr | alloc;
    assign link_waddr = cmd.clear ? clr_cnt_reg[AW-1:0] : slot_reg;
    assign link_wdata = cmd.clear ? '0 : nodes_used_reg[NW-1:0];
    assign mark_addr  = cmd.clear ? clr_cnt_reg[NW-1:0] : cursor_reg;
    assign mark_we    = mark_clr
                        | (cmd.finish && word_ok && (item_reg.cmd == CMD_INSERT));

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.capture && in_letter_ok)
        begin
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_addr] <= 1'b1 & !cmd.clear;
        end
        if (cmd.finish)
        begin
            mark_rd_reg <= mark_mem[mark_addr];
        end
    end

    always_comb
    begin
        cursor_next        = cursor_reg;
        nodes_used_next    = nodes_used_reg;
        path_missing_next  = path_missing_reg;
        pool_overflow_next = pool_overflow_reg;
        clr_cnt_next       = clr_cnt_reg;
        out_valid_next     = out_valid_reg & !out_ready;
        result_next        = result_reg;

        if (link_clr)
        begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
        end

        if (cmd.step && !broken)
        begin
            if (bad_letter)
            begin
                path_missing_next = 1'b1;
            end
            else if (link_rd_reg != '0)
            begin
                cursor_next = link_rd_reg;
            end
            else if (item_reg.cmd == CMD_SEARCH)
            begin
                path_missing_next = 1'b1;
            end
            else if (pool_full)
            begin
                pool_overflow_next = 1'b1;
            end
            else
            begin
                cursor_next     = nodes_used_reg[NW-1:0];
                nodes_used_next = nodes_used_reg + UW'(1);
            end
        end

        if (cmd.emit)
        begin
            result_next.found  = word_ok
                                 && ((item_reg.cmd == CMD_INSERT) || mark_rd_reg);
            result_next.status = pool_overflow_reg;
            out_valid_next     = 1'b1;
            // return to the root for the next word
            cursor_next        = '0;
            path_missing_next  = 1'b0;
            pool_overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg        <= '0;
            nodes_used_reg    <= UW'(1);
            path_missing_reg  <= 1'b0;
            pool_overflow_reg <= 1'b0;
            clr_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            cursor_reg        <= cursor_next;
            nodes_used_reg    <= nodes_used_next;
            path_missing_reg  <= path_missing_next;
            pool_overflow_reg <= pool_overflow_next;
            clr_cnt_reg       <= clr_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.capture)
        begin
            item_reg <= item;
            slot_reg <= rd_addr;
        end
    end

    assign stat.clear_done = clr_cnt_reg == CW'(LINK_DEPTH);
    assign stat.last       = item_reg.last_letter;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign result          = result_reg;

    a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nodes_used_reg != '0) && (nodes_used_reg <= UW'(NODE_COUNT)))
        else $error("node counter out of range");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> (nodes_used_reg == $past(nodes_used_reg) + UW'(1)))
        else $error("allocation did not advance the node counter");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transfer");

    a_word_close: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (cursor_reg == '0) && !path_missing_reg && !pool_overflow_reg)
        else $error("word state not returned to root after result");

endmodule

>>> sv/trie_word_insert_search.sv
// A non-final letter drops ready during the walk state only; a final letter goes
// through the walk, mark and done states, and out_valid rises with ready back in
// the same cycle; the done state waits while the result register is still full.
// A new letter is taken only once the last one is through, set by the single-port
// child link memory read then read-dependent write of each letter.
// Reset: clears all NODE_COUNT*ALPHABET_SIZE link entries (26624 by default)
// ----------------------------------------------------------------------------
// trie_word_insert_search: trie dictionary over a small alphabet
// Words arrive one letter per transfer; insert allocates nodes from a counter,
// search follows existing links; the final letter yields found and status.
// The clearing pass zeroes the link and end mark memories; ready rises in the
// cycle after it ends.
// ----------------------------------------------------------------------------
module trie_word_insert_search #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  twis_pkg::in_item_t   item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output twis_pkg::out_item_t  result
);
    import twis_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    twis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    twis_dp #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: trie word insert/search
// Sends words one letter per transfer, keeps a local trie in step with every
// accepted letter to work out each word's found/status (typed directed rows
// give a listed value instead), and checks result transfers in order. The run
// covers a directed list, then random words. It fills the node pool and then keeps running with the pool full.
// ----------------------------------------------------------------------------
module testbench;
    import twis_pkg::*;

    localparam int NODES       = 1024;
    localparam int ALPHA       = 26;
    localparam int MAX_LEN     = 16;
    localparam int DICT_CAP    = 512;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 20;

    localparam logic [LETTER_W-1:0] L_A   = LETTER_W'(0);
    localparam logic [LETTER_W-1:0] L_B   = LETTER_W'(1);
    localparam logic [LETTER_W-1:0] L_Q   = LETTER_W'(16);
    localparam logic [LETTER_W-1:0] L_R   = LETTER_W'(17);
    localparam logic [LETTER_W-1:0] L_Z   = LETTER_W'(25);
    localparam logic [LETTER_W-1:0] L_BAD = LETTER_W'(ALPHA);
    localparam logic [LETTER_W-1:0] L_TOP = '1;

    localparam logic MORE    = 1'b0;
    localparam logic LAST    = 1'b1;
    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    localparam out_item_t MISS = '{found: 1'b0, status: 1'b0};
    localparam out_item_t HIT  = '{found: 1'b1, status: 1'b0};

    typedef struct packed {
        in_item_t  it;
        logic      typed;
        out_item_t want;
    } plan_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  item      = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t result;

    trie_word_insert_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    always #10 clk = ~clk;

    // Local trie, same reset state as the block after its clearing pass
    bit [9:0]  trie_link [0:NODES*ALPHA-1];
    bit        trie_end  [0:NODES-1];
    bit [10:0] trie_used    = 11'd1;
    bit [9:0]  trie_cursor  = '0;
    bit        trie_no_path = 1'b0;
    bit        trie_full    = 1'b0;

    out_item_t word_verdicts_q [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  letters_sent  = 0;
    int  err_count     = 0;
    int  cycle_count   = 0;
    bit  last_found    = 1'b0;

    // Word being built for the random part, plus stored words for reuse
    logic [LETTER_W-1:0] w_letter [0:MAX_LEN-1];
    logic                w_cmd    [0:MAX_LEN-1];
    int                  w_len;
    logic [LETTER_W-1:0] dict_word [0:DICT_CAP-1][0:MAX_LEN-1];
    int                  dict_len  [0:DICT_CAP-1];
    int                  dict_count = 0;

    plan_row_t directed_plan [0:20] = '{
        '{'{CMD_SEARCH, L_A,   LAST}, TYPED,   MISS},  // empty trie
        '{'{CMD_INSERT, L_A,   LAST}, TYPED,   HIT},
        '{'{CMD_SEARCH, L_A,   LAST}, TYPED,   HIT},
        '{'{CMD_INSERT, L_Z,   MORE}, PREDICT, MISS},
        '{'{CMD_INSERT, L_A,   MORE}, PREDICT, MISS},
        '{'{CMD_INSERT, L_Z,   LAST}, TYPED,   HIT},
        '{'{CMD_SEARCH, L_Z,   MORE}, PREDICT, MISS},
        '{'{CMD_SEARCH, L_A,   LAST}, TYPED,   MISS},  // prefix, no end mark
        '{'{CMD_SEARCH, L_Z,   MORE}, PREDICT, MISS},
        '{'{CMD_SEARCH, L_A,   MORE}, PREDICT, MISS},
        '{'{CMD_SEARCH, L_Z,   LAST}, TYPED,   HIT},
        '{'{CMD_INSERT, L_BAD, LAST}, TYPED,   MISS},  // letter out of range
        '{'{CMD_SEARCH, L_B,   MORE}, PREDICT, MISS},
        '{'{CMD_SEARCH, L_TOP, LAST}, TYPED,   MISS},
        '{'{CMD_INSERT, L_Q,   MORE}, PREDICT, MISS},  // mixed commands
        '{'{CMD_SEARCH, L_R,   LAST}, PREDICT, MISS},
        '{'{CMD_SEARCH, L_Q,   LAST}, PREDICT, MISS},
        '{'{CMD_INSERT, L_TOP, MORE}, PREDICT, MISS},  // broken word
        '{'{CMD_INSERT, L_B,   LAST}, TYPED,   MISS},
        '{'{CMD_INSERT, L_A,   MORE}, PREDICT, MISS},
        '{'{CMD_INSERT, L_B,   LAST}, TYPED,   HIT}
    };

    // Advance the local trie by one letter; returns 1 when the word closes
    function automatic bit trie_walk_letter(input in_item_t it, output out_item_t res);
        int         slot;
        logic [9:0] nxt;
        bit         ok;
        res = '0;
        if (!trie_no_path && !trie_full) begin
            if (it.letter >= ALPHA) begin
                trie_no_path = 1'b1;
            end else begin
                slot = int'(trie_cursor) * ALPHA + int'(it.letter);
                nxt  = trie_link[slot];
                if (nxt != '0) begin
                    trie_cursor = nxt;
                end else if (it.cmd == CMD_SEARCH) begin
                    trie_no_path = 1'b1;
                end else if (trie_used >= NODES) begin
                    trie_full = 1'b1;
                end else begin
                    trie_link[slot] = trie_used[9:0];
                    trie_cursor     = trie_used[9:0];
                    trie_used       = trie_used + 11'd1;
                end
            end
        end
        if (!it.last_letter)
            return 1'b0;
        ok = !trie_no_path && !trie_full;
        if (it.cmd == CMD_SEARCH) begin
            res.found = ok && trie_end[trie_cursor];
        end else if (ok) begin
            trie_end[trie_cursor] = 1'b1;
            res.found = 1'b1;
        end
        res.status   = trie_full;
        trie_cursor  = '0;
        trie_no_path = 1'b0;
        trie_full    = 1'b0;
        return 1'b1;
    endfunction

    task automatic log_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_letter(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        item     <= it;
        do @(posedge clk); while (!in_ready);
        if (trie_walk_letter(it, res)) begin
            word_verdicts_q.push_back(typed ? want : res);
            last_found = res.found;
        end
        letters_sent++;
        @(negedge clk);
    endtask

    task automatic make_word(input bit filling);
        int   roll;
        int   d;
        logic cmd;
        bit   noise;
        roll  = $urandom_range(99);
        d     = (dict_count > 0) ? $urandom_range(dict_count - 1) : 0;
        cmd   = CMD_INSERT;
        noise = 1'b0;
        w_len = $urandom_range(8, 1);
        for (int i = 0; i < MAX_LEN; i++)
            w_letter[i] = LETTER_W'($urandom_range(ALPHA - 1));
        if (filling && roll < 95) begin
            // long fresh words allocate almost one node per letter
            w_len = $urandom_range(MAX_LEN, 10);
        end else if (roll >= 88) begin
            noise = 1'b1;
        end else if (roll >= 78) begin
            cmd = CMD_SEARCH;
        end else if (roll >= 20 && dict_count > 0) begin
            w_len = dict_len[d];
            for (int i = 0; i < MAX_LEN; i++)
                w_letter[i] = dict_word[d][i];
            if (roll >= 35)
                cmd = CMD_SEARCH;
            if (roll >= 60 && roll < 70)
                w_len = $urandom_range(w_len, 1);
            else if (roll >= 70)
                w_letter[$urandom_range(w_len - 1)] = LETTER_W'($urandom_range(ALPHA - 1));
        end
        for (int i = 0; i < MAX_LEN; i++) begin
            w_cmd[i] = noise ? 1'($urandom_range(1)) : cmd;
            if (noise && $urandom_range(99) < 30)
                w_letter[i] = LETTER_W'($urandom_range(int'(L_TOP), ALPHA));
        end
    endtask

    task automatic send_word();
        in_item_t it;
        int       d;
        for (int i = 0; i < w_len; i++) begin
            it.cmd         = w_cmd[i];
            it.letter      = w_letter[i];
            it.last_letter = (i == w_len - 1);
            send_letter(it, PREDICT, MISS);
        end
        // keep stored words around for repeat inserts and hit searches
        if (w_cmd[w_len-1] == CMD_INSERT && last_found) begin
            d = (dict_count < DICT_CAP) ? dict_count : $urandom_range(DICT_CAP - 1);
            if (dict_count < DICT_CAP)
                dict_count++;
            dict_len[d] = w_len;
            for (int i = 0; i < MAX_LEN; i++)
                dict_word[d][i] = w_letter[i];
        end
    endtask

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_result
        out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (word_verdicts_q.size() == 0) begin
                log_error($sformatf("unexpected result transfer: found=%0b status=%0b",
                                    result.found, result.status));
            end else begin
                want = word_verdicts_q.pop_front();
                if (result.found !== want.found || result.status !== want.status)
                    log_error($sformatf("result mismatch: exp found=%0b status=%0b, got found=%0b status=%0b",
                                        want.found, want.status, result.found, result.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int stop_at;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 72;
        foreach (directed_plan[r])
            send_letter(directed_plan[r].it, directed_plan[r].typed, directed_plan[r].want);
        while (letters_sent < 220) begin
            make_word(1'b0);
            send_word();
        end

        // fill the node pool, then keep going a while with it full
        send_idle_pct = 72;
        recv_idle_pct = 11;
        while (trie_used < NODES || letters_sent < 600) begin
            make_word(trie_used < NODES);
            send_word();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stop_at = letters_sent + 250;
        while (letters_sent < stop_at) begin
            make_word(1'b0);
            send_word();
        end
        in_valid <= 1'b0;

        while (word_verdicts_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (err_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
sv/twis_pkg.sv
sv/twis_ctrl.sv
sv/twis_dp.sv
sv/trie_word_insert_search.sv
tb/testbench.sv
